// File: rtl/core/hlv_pkg.sv
// ----------------------------------------------------------------------------
// hlv_pkg
// Shared types and constants of the line hough vote accumulator.
// ----------------------------------------------------------------------------
package hlv_pkg;

    // command codes
    localparam logic [1:0] CMD_VOTE  = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_RHO_OFFSET    = 2'd0;
    localparam logic [1:0] CFG_INV_RHO_STEP  = 2'd1;
    localparam logic [1:0] CFG_RHO_BIN_COUNT = 2'd2;

    localparam logic [11:0] RHO_OFFSET_RST    = 12'd801;
    localparam logic [15:0] INV_RHO_STEP_RST  = 16'd4096;
    localparam logic [11:0] RHO_BIN_COUNT_RST = 12'd1602;

    // pi in q30 and the cell saturation limit
    localparam logic [63:0] PI_Q30    = 64'd3373259426;
    localparam logic [18:0] COUNT_MAX = 19'd524287;

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  pixel_value;
        logic [9:0]  pixel_x;
        logic [8:0]  pixel_y;
        logic [7:0]  angle_index;
        logic [10:0] rho_index;
    } t_in;

    typedef struct packed {
        logic [18:0] vote_count;
        logic [7:0]  vote_byte;
    } t_out;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_VOTE,
        ST_DRAIN,
        ST_RD_ADDR,
        ST_RD_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic issue;
        logic clr_start;
        logic clr_en;
        logic rd_sel;
        logic out_load;
    } t_ctrl_cmd;

    // datapath to controller
    typedef struct packed {
        logic vote_ok;
        logic last_angle;
        logic pipe_empty;
        logic clr_done;
    } t_dp_status;

endpackage

// File: rtl/core/hough_line_vote_accumulator_top.sv
// ----------------------------------------------------------------------------
// hough_line_vote_accumulator_top
// Line hough voting engine with a rho/theta accumulator memory.
// ----------------------------------------------------------------------------
// A vote keeps busy high for one memory
// read-modify-write per angle step through a six stage pipeline behind the
// angle counter, then a drain until the pipeline is empty. A vote from a zero
// or out-of-frame pixel, and a no-op command, leave busy low. A read keeps
// busy high through ST_RD_ADDR and ST_RD_OUT; its result strobe on o_valid
// comes in the cycle busy falls, registered from ST_RD_OUT. The strobe lasts one
// cycle and cannot be held off. A clear, and also the period right after
// reset, sweeps all ANGLE_COUNT * 2**clog2(RHO_BINS_MAX) cells (368640 by
// default) one cell a cycle, while busy is high. Configuration writes
// are taken at any time and should be made while the block is idle.
module hough_line_vote_accumulator_top #(
    parameter int ANGLE_COUNT  = 180,
    parameter int RHO_BINS_MAX = 2048,
    parameter int MAX_WIDTH    = 640,
    parameter int MAX_HEIGHT   = 480
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  hlv_pkg::t_in  i_in,
    output logic          o_valid,
    output hlv_pkg::t_out o_result,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_index,
    input  logic [15:0]   i_cfg_data
);

    logic [11:0] r_rho_offset;
    logic [15:0] r_inv_rho_step;
    logic [11:0] r_rho_bin_count;

    hlv_pkg::t_ctrl_cmd  cmd;
    hlv_pkg::t_dp_status status;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rho_offset    <= hlv_pkg::RHO_OFFSET_RST;
            r_inv_rho_step  <= hlv_pkg::INV_RHO_STEP_RST;
            r_rho_bin_count <= hlv_pkg::RHO_BIN_COUNT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                hlv_pkg::CFG_RHO_OFFSET:    r_rho_offset    <= i_cfg_data[11:0];
                hlv_pkg::CFG_INV_RHO_STEP:  r_inv_rho_step  <= i_cfg_data;
                hlv_pkg::CFG_RHO_BIN_COUNT: r_rho_bin_count <= i_cfg_data[11:0];
                default: begin
                end
            endcase
        end
    end

    hlv_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_command (i_in.command),
        .i_status  (status),
        .o_busy    (busy),
        .o_cmd     (cmd)
    );

    hlv_dp #(
        .ANGLE_COUNT  (ANGLE_COUNT),
        .RHO_BINS_MAX (RHO_BINS_MAX),
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_HEIGHT   (MAX_HEIGHT)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in            (i_in),
        .i_cmd           (cmd),
        .i_rho_offset    (r_rho_offset),
        .i_inv_rho_step  (r_inv_rho_step),
        .i_rho_bin_count (r_rho_bin_count),
        .o_status        (status),
        .o_valid         (o_valid),
        .o_result        (o_result)
    );

endmodule

// File: rtl/core/hlv_trig_rom.sv
// ----------------------------------------------------------------------------
// hlv_trig_rom
// Q1.15 cosine and sine table over the angle steps, registered read.
// ----------------------------------------------------------------------------
module hlv_trig_rom #(
    parameter int ANGLE_COUNT = 180,
    parameter int AW          = 8
) (
    input  logic                i_clk,
    input  logic [AW-1:0]       i_addr,
    output logic signed [15:0]  o_cos,
    output logic signed [15:0]  o_sin
);

    logic signed [15:0] cos_tab [ANGLE_COUNT];
    logic signed [15:0] sin_tab [ANGLE_COUNT];
    logic signed [15:0] r_cos;
    logic signed [15:0] r_sin;

    // taylor series in q30 on the angle folded into the first quadrant
    for (genvar g = 0; g < ANGLE_COUNT; g++) begin : g_ent
        localparam logic [63:0] T0  = (64'(g) * hlv_pkg::PI_Q30) / 64'(ANGLE_COUNT);
        localparam bit          NEG = T0 > (hlv_pkg::PI_Q30 / 64'd2);
        localparam logic [63:0] T   = NEG ? (hlv_pkg::PI_Q30 - T0) : T0;
        localparam logic [63:0] T2  = (T * T) >> 30;
        localparam logic [63:0] ONE = 64'd1 << 30;
        localparam logic [63:0] C1  = ((ONE * T2) >> 30) / 64'd2;
        localparam logic [63:0] C2  = ((C1 * T2) >> 30) / 64'd12;
        localparam logic [63:0] C3  = ((C2 * T2) >> 30) / 64'd30;
        localparam logic [63:0] C4  = ((C3 * T2) >> 30) / 64'd56;
        localparam logic [63:0] C5  = ((C4 * T2) >> 30) / 64'd90;
        localparam logic [63:0] C6  = ((C5 * T2) >> 30) / 64'd132;
        localparam logic [63:0] C7  = ((C6 * T2) >> 30) / 64'd182;
        localparam logic [63:0] C8  = ((C7 * T2) >> 30) / 64'd240;
        localparam logic [63:0] C9  = ((C8 * T2) >> 30) / 64'd306;
        localparam logic [63:0] C10 = ((C9 * T2) >> 30) / 64'd380;
        localparam logic [63:0] C11 = ((C10 * T2) >> 30) / 64'd462;
        localparam logic [63:0] C12 = ((C11 * T2) >> 30) / 64'd552;
        localparam logic [63:0] S1  = ((T * T2) >> 30) / 64'd6;
        localparam logic [63:0] S2  = ((S1 * T2) >> 30) / 64'd20;
        localparam logic [63:0] S3  = ((S2 * T2) >> 30) / 64'd42;
        localparam logic [63:0] S4  = ((S3 * T2) >> 30) / 64'd72;
        localparam logic [63:0] S5  = ((S4 * T2) >> 30) / 64'd110;
        localparam logic [63:0] S6  = ((S5 * T2) >> 30) / 64'd156;
        localparam logic [63:0] S7  = ((S6 * T2) >> 30) / 64'd210;
        localparam logic [63:0] S8  = ((S7 * T2) >> 30) / 64'd272;
        localparam logic [63:0] S9  = ((S8 * T2) >> 30) / 64'd342;
        localparam logic [63:0] S10 = ((S9 * T2) >> 30) / 64'd420;
        localparam logic [63:0] S11 = ((S10 * T2) >> 30) / 64'd506;
        localparam logic [63:0] S12 = ((S11 * T2) >> 30) / 64'd600;
        localparam logic [63:0] CP  = ONE - C1 + C2 - C3 + C4 - C5 + C6 - C7 + C8 - C9
                                      + C10 - C11 + C12;
        localparam logic [63:0] SP  = T - S1 + S2 - S3 + S4 - S5 + S6 - S7 + S8 - S9
                                      + S10 - S11 + S12;
        localparam logic [63:0] CV  = NEG ? (64'd0 - CP) : CP;
        // q30 to q15 with rounding and saturation
        localparam logic signed [63:0] CR = $signed(((CV + (64'd1 << 32)) + 64'd16384) >> 15)
                                            - 64'sd131072;
        localparam logic signed [63:0] SR = $signed(((SP + (64'd1 << 32)) + 64'd16384) >> 15)
                                            - 64'sd131072;
        localparam logic signed [63:0] CQ = (CR > 64'sd32767) ? 64'sd32767 :
                                            (CR < -64'sd32768) ? -64'sd32768 : CR;
        localparam logic signed [63:0] SQ = (SR > 64'sd32767) ? 64'sd32767 :
                                            (SR < -64'sd32768) ? -64'sd32768 : SR;
        assign cos_tab[g] = 16'(CQ);
        assign sin_tab[g] = 16'(SQ);
    end

    // registered lookup
    always_ff @(posedge i_clk) begin
        r_cos <= cos_tab[i_addr];
        r_sin <= sin_tab[i_addr];
    end

    assign o_cos = r_cos;
    assign o_sin = r_sin;

endmodule

// File: rtl/core/hlv_ctrl.sv
// ----------------------------------------------------------------------------
// hlv_ctrl
// Command sequencer: clear sweep, vote issue and drain, cell read.
// ----------------------------------------------------------------------------
module hlv_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [1:0]          i_command,
    input  hlv_pkg::t_dp_status i_status,
    output logic                o_busy,
    output hlv_pkg::t_ctrl_cmd  o_cmd
);

    hlv_pkg::t_state r_state;
    hlv_pkg::t_state n_state;
    logic            accept;

    assign accept = i_start && (r_state == hlv_pkg::ST_IDLE);

    // state register, clear sweep runs out of reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hlv_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            hlv_pkg::ST_CLEAR: begin
                if (i_status.clr_done) n_state = hlv_pkg::ST_IDLE;
            end
            hlv_pkg::ST_IDLE: begin
                if (i_start) begin
                    case (i_command)
                        hlv_pkg::CMD_VOTE: begin
                            if (i_status.vote_ok) n_state = hlv_pkg::ST_VOTE;
                        end
                        hlv_pkg::CMD_READ:  n_state = hlv_pkg::ST_RD_ADDR;
                        hlv_pkg::CMD_CLEAR: n_state = hlv_pkg::ST_CLEAR;
                        default:            n_state = hlv_pkg::ST_IDLE;
                    endcase
                end
            end
            hlv_pkg::ST_VOTE: begin
                if (i_status.last_angle) n_state = hlv_pkg::ST_DRAIN;
            end
            hlv_pkg::ST_DRAIN: begin
                if (i_status.pipe_empty) n_state = hlv_pkg::ST_IDLE;
            end
            hlv_pkg::ST_RD_ADDR: n_state = hlv_pkg::ST_RD_OUT;
            hlv_pkg::ST_RD_OUT:  n_state = hlv_pkg::ST_IDLE;
            default:             n_state = hlv_pkg::ST_IDLE;
        endcase
    end

    // datapath commands
    always_comb begin
        o_busy          = (r_state != hlv_pkg::ST_IDLE);
        o_cmd           = '0;
        o_cmd.capture   = accept;
        o_cmd.clr_start = accept && (i_command == hlv_pkg::CMD_CLEAR);
        o_cmd.issue     = (r_state == hlv_pkg::ST_VOTE);
        o_cmd.clr_en    = (r_state == hlv_pkg::ST_CLEAR);
        o_cmd.rd_sel    = (r_state == hlv_pkg::ST_RD_ADDR);
        o_cmd.out_load  = (r_state == hlv_pkg::ST_RD_OUT);
    end

endmodule

// File: rtl/core/hlv_dp.sv
// ----------------------------------------------------------------------------
// hlv_dp
// Vote pipeline, accumulator memory, clear sweep and read result register.
// ----------------------------------------------------------------------------
module hlv_dp #(
    parameter int ANGLE_COUNT  = 180,
    parameter int RHO_BINS_MAX = 2048,
    parameter int MAX_WIDTH    = 640,
    parameter int MAX_HEIGHT   = 480
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  hlv_pkg::t_in        i_in,
    input  hlv_pkg::t_ctrl_cmd  i_cmd,
    input  logic [11:0]         i_rho_offset,
    input  logic [15:0]         i_inv_rho_step,
    input  logic [11:0]         i_rho_bin_count,
    output hlv_pkg::t_dp_status o_status,
    output logic                o_valid,
    output hlv_pkg::t_out       o_result
);

    localparam int AW        = (ANGLE_COUNT > 1) ? $clog2(ANGLE_COUNT) : 1;
    localparam int RB        = $clog2(RHO_BINS_MAX);
    localparam int MW        = AW + RB;
    localparam int MEM_DEPTH = ANGLE_COUNT * (2 ** RB);

    logic [18:0] mem [MEM_DEPTH];

    // captured item
    logic [9:0]    r_x;
    logic [8:0]    r_y;
    logic [MW-1:0] r_rd_addr;
    logic          r_rd_oob;

    // angle issue counter and clear sweep counter
    logic [AW-1:0] r_angle;
    logic [MW-1:0] r_clr_addr;

    // pipeline stages
    logic [5:0]            r_v;
    logic [AW-1:0]         r_a1, r_a2, r_a3, r_a4;
    logic signed [26:0]    r_pc;
    logic signed [25:0]    r_ps;
    logic signed [28:0]    r_sum;
    logic [16:0]           r_bin;
    logic [MW-1:0]         r_addr5, r_addr6;
    logic [18:0]           r_rdata;

    logic signed [15:0]    cos1, sin1;
    logic [43:0]           prod;
    logic [RB:0]           bins_eff;
    logic [RB-1:0]         bin_clamp;
    logic [MW-1:0]         rd_addr;
    logic [18:0]           cnt_inc;

    logic                  r_out_valid;
    hlv_pkg::t_out         r_out;

    // trig lookup, registered inside the rom
    hlv_trig_rom #(
        .ANGLE_COUNT (ANGLE_COUNT),
        .AW          (AW)
    ) u_rom (
        .i_clk  (i_clk),
        .i_addr (r_angle),
        .o_cos  (cos1),
        .o_sin  (sin1)
    );

    // item capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_x       <= i_in.pixel_x;
            r_y       <= i_in.pixel_y;
            r_rd_addr <= {AW'(i_in.angle_index), RB'(i_in.rho_index)};
            r_rd_oob  <= (32'(i_in.angle_index) >= ANGLE_COUNT) ||
                         (32'(i_in.rho_index) >= RHO_BINS_MAX);
        end
    end

    // angle counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle <= '0;
        end else if (i_cmd.capture) begin
            r_angle <= '0;
        end else if (i_cmd.issue) begin
            r_angle <= r_angle + AW'(1);
        end
    end

    // clear sweep counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_start) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_en) begin
            r_clr_addr <= r_clr_addr + MW'(1);
        end
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[4:0], i_cmd.issue};
        end
    end

    // products, offset sum and reciprocal scale
    assign prod = 44'(r_sum[27:0]) * 44'(i_inv_rho_step);

    always_ff @(posedge i_clk) begin
        r_a1  <= r_angle;
        r_pc  <= 27'(cos1 * $signed({1'b0, r_x}));
        r_ps  <= 26'(sin1 * $signed({1'b0, r_y}));
        r_a2  <= r_a1;
        r_sum <= 29'(r_pc) + 29'(r_ps) + $signed({2'b0, i_rho_offset, 15'd0});
        r_a3  <= r_a2;
        r_bin <= r_sum[28] ? 17'd0 : prod[43:27];
        r_a4  <= r_a3;
    end

    // effective bin count and clamp
    always_comb begin
        if (i_rho_bin_count == 12'd0) begin
            bins_eff = (RB + 1)'(1);
        end else if (32'(i_rho_bin_count) > RHO_BINS_MAX) begin
            bins_eff = (RB + 1)'(RHO_BINS_MAX);
        end else begin
            bins_eff = (RB + 1)'(i_rho_bin_count);
        end
        if (32'(r_bin) >= 32'(bins_eff)) begin
            bin_clamp = RB'(bins_eff - (RB + 1)'(1));
        end else begin
            bin_clamp = RB'(r_bin);
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr5 <= {r_a4, bin_clamp};
        r_addr6 <= r_addr5;
    end

    // memory read and write ports
    assign rd_addr = i_cmd.rd_sel ? r_rd_addr : r_addr5;
    assign cnt_inc = (r_rdata == hlv_pkg::COUNT_MAX) ? r_rdata : r_rdata + 19'd1;

    always_ff @(posedge i_clk) begin
        if (r_v[4] || i_cmd.rd_sel) begin
            r_rdata <= mem[rd_addr];
        end
        if (i_cmd.clr_en) begin
            mem[r_clr_addr] <= '0;
        end else if (r_v[5]) begin
            mem[r_addr6] <= cnt_inc;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= i_cmd.out_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.vote_count <= r_rd_oob ? 19'd0 : r_rdata;
            r_out.vote_byte  <= r_rd_oob ? 8'd0 : r_rdata[7:0];
        end
    end

    // status
    always_comb begin
        o_status.vote_ok    = (i_in.pixel_value != 8'd0) &&
                              (32'(i_in.pixel_x) < MAX_WIDTH) &&
                              (32'(i_in.pixel_y) < MAX_HEIGHT);
        o_status.last_angle = i_cmd.issue && (32'(r_angle) == ANGLE_COUNT - 1);
        o_status.pipe_empty = (r_v == '0);
        o_status.clr_done   = i_cmd.clr_en && (32'(r_clr_addr) == MEM_DEPTH - 1);
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

// File: tb/tb_hough_line_vote_accumulator_top.sv
// ----------------------------------------------------------------------------
// tb_hough_line_vote_accumulator_top
// Self-checking bench for the line hough vote accumulator. Votes, reads and
// clears are driven through the command port. An in-bench model of the
// trig tables, bin arithmetic and vote store predicts every read result,
// and each read strobe is compared field by field against it.
// ----------------------------------------------------------------------------
module tb_hough_line_vote_accumulator_top;

    localparam int  ANGLES     = 180;
    localparam int  BINS_MAX   = 2048;
    localparam int  FRAME_W    = 640;
    localparam int  FRAME_H    = 480;
    localparam int  SETTLE_CYC = ANGLES + 20;
    localparam longint LIMIT   = 10000000;
    localparam logic [1:0] CMD_NOP  = 2'd3;
    localparam logic [1:0] CFG_NONE = 2'd3;
    localparam int  N_RANDOM   = 1450;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          start = 1'b0;
    logic          busy;
    hlv_pkg::t_in  i_in = '0;
    logic          o_valid;
    hlv_pkg::t_out o_result;
    logic          i_cfg_we = 1'b0;
    logic [1:0]    i_cfg_index = '0;
    logic [15:0]   i_cfg_data = '0;

    hough_line_vote_accumulator_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_in        (i_in),
        .o_valid     (o_valid),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // model state
    int            cos_tab [ANGLES];
    int            sin_tab [ANGLES];
    int unsigned   cell_count [int];
    int unsigned   offset_reg = 32'(hlv_pkg::RHO_OFFSET_RST);
    int unsigned   inv_step_reg = 32'(hlv_pkg::INV_RHO_STEP_RST);
    int unsigned   bin_count_reg = 32'(hlv_pkg::RHO_BIN_COUNT_RST);
    hlv_pkg::t_out read_expect_q [$];
    int            mismatches = 0;
    int            idle_pct = 0;
    longint        cycle_count = 0;
    hlv_pkg::t_in  voted_px [$];

    // q30 to q15 with round to nearest and saturation
    function automatic int to_q15(longint v);
        longint r;
        r = ((v + (longint'(1) << 32) + (longint'(1) << 14)) >>> 15) - (longint'(1) << 17);
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return int'(r);
    endfunction

    // taylor series cos/sin tables over the half turn
    function automatic void build_trig_tables();
        longint unsigned t, t2, term;
        longint c, s;
        bit neg;
        for (int i = 0; i < ANGLES; i++) begin
            t = (longint'(i) * hlv_pkg::PI_Q30) / ANGLES;
            neg = 1'b0;
            if (t > hlv_pkg::PI_Q30 / 2) begin
                t = hlv_pkg::PI_Q30 - t;
                neg = 1'b1;
            end
            t2 = (t * t) >> 30;
            term = 64'd1 << 30;
            c = longint'(term);
            for (int k = 1; k <= 12; k++) begin
                term = ((term * t2) >> 30) / longint'((2 * k - 1) * (2 * k));
                if (k % 2) c -= longint'(term); else c += longint'(term);
            end
            term = t;
            s = longint'(term);
            for (int k = 1; k <= 12; k++) begin
                term = ((term * t2) >> 30) / longint'((2 * k) * (2 * k + 1));
                if (k % 2) s -= longint'(term); else s += longint'(term);
            end
            if (neg) c = -c;
            cos_tab[i] = to_q15(c);
            sin_tab[i] = to_q15(s);
        end
    endfunction

    function automatic int rho_bin(int a, int x, int y);
        longint sum;
        longint unsigned b;
        int unsigned nb;
        nb = bin_count_reg;
        if (nb == 0) nb = 1;
        if (nb > BINS_MAX) nb = BINS_MAX;
        sum = longint'(cos_tab[a]) * x + longint'(sin_tab[a]) * y
            + longint'(offset_reg) * 32768;
        if (sum < 0) b = 0;
        else b = (longint'(sum) * longint'(inv_step_reg)) >> 27;
        if (b >= nb) b = nb - 1;
        return int'(b);
    endfunction

    // apply one accepted command to the model vote store
    function automatic void predict_command(hlv_pkg::t_in it);
        int key;
        int unsigned v;
        hlv_pkg::t_out r;
        case (it.command)
            hlv_pkg::CMD_VOTE: begin
                if (it.pixel_value != 0 && it.pixel_x < FRAME_W && it.pixel_y < FRAME_H) begin
                    for (int a = 0; a < ANGLES; a++) begin
                        key = a * BINS_MAX + rho_bin(a, it.pixel_x, it.pixel_y);
                        v = cell_count.exists(key) ? cell_count[key] : 0;
                        if (v < hlv_pkg::COUNT_MAX) cell_count[key] = v + 1;
                    end
                end
            end
            hlv_pkg::CMD_READ: begin
                v = 0;
                key = it.angle_index * BINS_MAX + it.rho_index;
                if (it.angle_index < ANGLES && it.rho_index < BINS_MAX
                    && cell_count.exists(key))
                    v = cell_count[key];
                r.vote_count = v[18:0];
                r.vote_byte  = v[7:0];
                read_expect_q = {read_expect_q, r};
            end
            hlv_pkg::CMD_CLEAR: cell_count.delete();
            default: ;
        endcase
    endfunction

    // result checker: one read beat per strobe
    always @(posedge i_clk) begin
        hlv_pkg::t_out exp_r;
        if (i_rst_n && o_valid) begin
            if (read_expect_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: count %0d byte %0d",
                             o_result.vote_count, o_result.vote_byte);
            end else begin
                exp_r = read_expect_q.pop_front();
                if (o_result.vote_count !== exp_r.vote_count
                    || o_result.vote_byte !== exp_r.vote_byte) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("read mismatch: exp count %0d byte %0d, got count %0d byte %0d",
                                 exp_r.vote_count, exp_r.vote_byte,
                                 o_result.vote_count, o_result.vote_byte);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // send one command beat; start stays high when no gap follows
    task automatic send_cmd(hlv_pkg::t_in it);
        start <= 1'b1;
        i_in  <= it;
        do @(posedge i_clk); while (busy);
        predict_command(it);
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    // wait until no reads are pending and the vote pipeline has drained
    task automatic wait_idle();
        start <= 1'b0;
        @(posedge i_clk);
        while (busy || read_expect_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            hlv_pkg::CFG_RHO_OFFSET:    offset_reg = 32'(val[11:0]);
            hlv_pkg::CFG_INV_RHO_STEP:  inv_step_reg = 32'(val);
            hlv_pkg::CFG_RHO_BIN_COUNT: bin_count_reg = 32'(val[11:0]);
            default: ;
        endcase
    endtask

    function automatic hlv_pkg::t_in mk_vote(int pix, int x, int y);
        hlv_pkg::t_in it;
        it = '0;
        it.command = hlv_pkg::CMD_VOTE;
        it.pixel_value = 8'(pix);
        it.pixel_x = 10'(x);
        it.pixel_y = 9'(y);
        it.angle_index = 8'($urandom);
        it.rho_index = 11'($urandom);
        return it;
    endfunction

    function automatic hlv_pkg::t_in mk_read(int a, int r);
        hlv_pkg::t_in it;
        it = '0;
        it.command = hlv_pkg::CMD_READ;
        it.pixel_value = 8'($urandom);
        it.pixel_x = 10'($urandom);
        it.pixel_y = 9'($urandom);
        it.angle_index = 8'(a);
        it.rho_index = 11'(r);
        return it;
    endfunction

    function automatic hlv_pkg::t_in mk_other(logic [1:0] cmd);
        hlv_pkg::t_in it;
        it = 48'({$urandom, $urandom});
        it.command = cmd;
        return it;
    endfunction

    // mostly real votes and reads of the cells that recent votes hit
    function automatic hlv_pkg::t_in random_item();
        int pick;
        hlv_pkg::t_in p;
        int a;
        pick = $urandom_range(99);
        if (pick < 45) begin
            p = mk_vote($urandom_range(1, 255), $urandom_range(FRAME_W - 1),
                        $urandom_range(FRAME_H - 1));
            voted_px = {voted_px, p};
            if (voted_px.size() > 16) void'(voted_px.pop_front());
            return p;
        end else if (pick < 85 && voted_px.size() != 0) begin
            p = voted_px[$urandom_range(voted_px.size() - 1)];
            a = $urandom_range(ANGLES - 1);
            return mk_read(a, rho_bin(a, p.pixel_x, p.pixel_y));
        end else if (pick < 90) begin
            return mk_read($urandom_range(255), $urandom_range(2047));
        end else if (pick < 94) begin
            return mk_vote(0, $urandom_range(1023), $urandom_range(511));
        end else if (pick < 97) begin
            return mk_vote($urandom_range(1, 255), $urandom_range(FRAME_W, 1023),
                           $urandom_range(511));
        end
        return mk_other(CMD_NOP);
    endfunction

    task automatic test_directed();
        send_cmd(mk_read(0, 0));
        send_cmd(mk_read(ANGLES - 1, BINS_MAX - 1));
        send_cmd(mk_read(ANGLES, 0));
        send_cmd(mk_read(255, 2047));
        send_cmd(mk_vote(255, 0, 0));
        send_cmd(mk_vote(1, FRAME_W - 1, FRAME_H - 1));
        send_cmd(mk_vote(128, 0, FRAME_H - 1));
        send_cmd(mk_vote(7, FRAME_W - 1, 0));
        send_cmd(mk_vote(0, 100, 100));
        send_cmd(mk_vote(9, FRAME_W, 10));
        send_cmd(mk_vote(9, 10, FRAME_H));
        send_cmd(mk_vote(255, 1023, 511));
        send_cmd(mk_other(CMD_NOP));
        send_cmd(mk_read(0, rho_bin(0, 0, 0)));
        send_cmd(mk_read(90, rho_bin(90, FRAME_W - 1, FRAME_H - 1)));
        send_cmd(mk_read(ANGLES - 1, rho_bin(ANGLES - 1, FRAME_W - 1, 0)));
        send_cmd(mk_read(45, rho_bin(45, 0, FRAME_H - 1)));
        send_cmd(mk_read(0, BINS_MAX - 1));
        send_cmd(mk_other(hlv_pkg::CMD_CLEAR));
        send_cmd(mk_read(0, rho_bin(0, 0, 0)));
        send_cmd(mk_read(90, rho_bin(90, FRAME_W - 1, FRAME_H - 1)));
    endtask

    // hold the sender off until every pending read has returned
    task automatic test_drain_pause();
        for (int i = 0; i < 6; i++) send_cmd(random_item());
        start <= 1'b0;
        @(posedge i_clk);
        while (read_expect_q.size() != 0) @(posedge i_clk);
        send_cmd(mk_read(0, 0));
    endtask

    task automatic test_register_sweep();
        logic [15:0] offs [5] = '{16'd1, 16'd2048, 16'd4095, 16'd0,
                                  16'(hlv_pkg::RHO_OFFSET_RST)};
        logic [15:0] steps [5] = '{16'd1, 16'd65535, 16'd300, 16'd0,
                                   hlv_pkg::INV_RHO_STEP_RST};
        logic [15:0] cnts [5] = '{16'd1, 16'd2048, 16'd4095, 16'd0,
                                  16'(hlv_pkg::RHO_BIN_COUNT_RST)};
        for (int s = 0; s < 5; s++) begin
            write_reg(hlv_pkg::CFG_RHO_OFFSET, offs[s]);
            write_reg(hlv_pkg::CFG_INV_RHO_STEP, steps[s]);
            write_reg(hlv_pkg::CFG_RHO_BIN_COUNT, cnts[s]);
            for (int i = 0; i < 20; i++) send_cmd(random_item());
        end
        write_reg(CFG_NONE, 16'hFFFF);
    endtask

    task automatic test_random_traffic();
        int pcts [3] = '{8, 57, 0};
        for (int ph = 0; ph < 3; ph++) begin
            idle_pct = pcts[ph];
            for (int i = 0; i < N_RANDOM / 3; i++) begin
                if (ph == 1 && i == 200) send_cmd(mk_other(hlv_pkg::CMD_CLEAR));
                send_cmd(random_item());
            end
        end
        idle_pct = 0;
    endtask

    initial begin
        build_trig_tables();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        idle_pct = 8;
        test_directed();
        test_register_sweep();
        test_drain_pause();
        test_random_traffic();
        wait_idle();
        if (mismatches == 0 && read_expect_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
